@@ design/cidt_pkg.sv @@
`timescale 1ns / 1ps

package cidt_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int NUM_BUSES   = 3;

  localparam int TABLES    = NUM_BUSES * 2;
  localparam int BUS_SEL_W = (NUM_BUSES > 1) ? $clog2(NUM_BUSES) : 1;
  localparam int TABLE_W   = BUS_SEL_W + 1;
  localparam int CNT_W     = $clog2(MAX_ENTRIES + 1);

  localparam int ID_W      = 29;
  localparam int HANDLE_W  = 8;
  localparam int PAYLOAD_W = 64;

  typedef enum logic [0:0] {
    OP_REGISTER = 1'b0,
    OP_FRAME    = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_DELIVERED  = 2'd0,
    ST_NO_MATCH   = 2'd1,
    ST_REGISTERED = 2'd2,
    ST_FULL       = 2'd3
  } status_t;

  typedef struct packed {
    logic [0:0]           op;
    logic [1:0]           bus;
    logic                 extended;
    logic [ID_W-1:0]      can_id;
    logic [HANDLE_W-1:0]  device_handle;
    logic [PAYLOAD_W-1:0] payload;
  } req_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [HANDLE_W-1:0]  target_handle;
    logic [PAYLOAD_W-1:0] frame_data;
  } rsp_t;

  typedef struct packed {
    logic [ID_W-1:0]     id;
    logic [HANDLE_W-1:0] handle;
  } entry_t;

  typedef struct packed {
    logic               load;
    logic [TABLE_W-1:0] load_table;
    logic               commit;
    logic [TABLE_W-1:0] table_sel;
    logic [ID_W-1:0]    key;
    entry_t             ins;
    logic [CNT_W-1:0]   cnt;
  } cell_ctl_t;

  function automatic logic [TABLE_W-1:0] pick_table(logic [1:0] bus, logic ext);
    logic [BUS_SEL_W-1:0] b;
    if (32'(bus) >= NUM_BUSES) begin
      b = BUS_SEL_W'(NUM_BUSES - 1);
    end else begin
      b = BUS_SEL_W'(bus);
    end
    return {b, ext};
  endfunction

endpackage

@@ design/cidt_cell.sv @@
`timescale 1ns / 1ps

module cidt_cell (
  input  logic                           clk,
  input  logic [cidt_pkg::CNT_W-1:0]     pos,
  input  cidt_pkg::cell_ctl_t            ctl,
  input  cidt_pkg::entry_t               prev_entry,
  input  logic                           prev_gt,
  output cidt_pkg::entry_t               entry,
  output logic                           gt,
  output logic                           match
);

  cidt_pkg::entry_t mem [cidt_pkg::TABLES];
  logic             valid;
  logic             at_end;
  logic             wr;
  cidt_pkg::entry_t wr_data;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      entry <= mem[ctl.load_table];
    end
  end

  assign valid  = pos < ctl.cnt;
  assign at_end = pos == ctl.cnt;
  assign gt     = valid && (entry.id > ctl.key);
  assign match  = valid && (entry.id == ctl.key);

  // shift from the left neighbour, else take the new word at the insert point
  assign wr      = ctl.commit && (prev_gt || gt || at_end);
  assign wr_data = prev_gt ? prev_entry : ctl.ins;

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[ctl.table_sel] <= wr_data;
    end
  end

endmodule

@@ design/can_id_dispatch_table.sv @@
`timescale 1ns / 1ps

// channel | direction | handshake          | word
// req     | in        | req_valid/req_stall | cidt_pkg::req_t
// rsp     | out       | rsp_valid/rsp_stall | cidt_pkg::rsp_t
//
// Each word first reads every cell's slot for the chosen table into a register,
// then compares across the cell row and inserts or picks the lowest match.
// A held rsp word stalls the compare step only; req is taken again once it clears.
// Synchronous reset clears the per-table counts and the handshake state; no sweep.

module can_id_dispatch_table (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_stall,
  input  cidt_pkg::req_t   req,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output cidt_pkg::rsp_t   rsp
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_LOOK = 2'b10
  } state_t;

  state_t                              state;
  logic [cidt_pkg::CNT_W-1:0]          counts [cidt_pkg::TABLES];
  logic [0:0]                          op;
  logic [cidt_pkg::TABLE_W-1:0]        table_sel;
  logic [cidt_pkg::ID_W-1:0]           key;
  logic [cidt_pkg::HANDLE_W-1:0]       handle;
  logic [cidt_pkg::PAYLOAD_W-1:0]      payload;

  logic                                accept;
  logic                                out_free;
  logic                                done;
  logic [cidt_pkg::CNT_W-1:0]          cnt;
  logic                                full;
  cidt_pkg::cell_ctl_t                 ctl;

  cidt_pkg::entry_t                    entries [cidt_pkg::MAX_ENTRIES];
  logic [cidt_pkg::MAX_ENTRIES-1:0]    gts;
  logic [cidt_pkg::MAX_ENTRIES-1:0]    hits;
  logic [cidt_pkg::MAX_ENTRIES-1:0]    first;
  logic [cidt_pkg::HANDLE_W-1:0]       hit_handle;
  cidt_pkg::rsp_t                      rsp_next;

  assign req_stall = state != S_IDLE;
  assign accept    = req_valid && !req_stall;
  assign out_free  = !rsp_valid || !rsp_stall;
  assign done      = (state == S_LOOK) && out_free;
  assign cnt       = counts[table_sel];
  assign full      = cnt >= cidt_pkg::CNT_W'(cidt_pkg::MAX_ENTRIES);

  always_comb begin
    ctl            = '0;
    ctl.load       = accept;
    ctl.load_table = cidt_pkg::pick_table(req.bus, req.extended);
    ctl.commit     = done && (op == cidt_pkg::OP_REGISTER) && !full;
    ctl.table_sel  = table_sel;
    ctl.key        = key;
    ctl.ins.id     = key;
    ctl.ins.handle = handle;
    ctl.cnt        = cnt;
  end

  for (genvar k = 0; k < cidt_pkg::MAX_ENTRIES; k++) begin : g_cell
    cidt_pkg::entry_t prev_entry;
    logic             prev_gt;
    if (k == 0) begin : g_head
      assign prev_entry = '0;
      assign prev_gt    = 1'b0;
    end else begin : g_link
      assign prev_entry = entries[k-1];
      assign prev_gt    = gts[k-1];
    end
    cidt_cell u_cell (
      .clk        (clk),
      .pos        (cidt_pkg::CNT_W'(k)),
      .ctl        (ctl),
      .prev_entry (prev_entry),
      .prev_gt    (prev_gt),
      .entry      (entries[k]),
      .gt         (gts[k]),
      .match      (hits[k])
    );
  end

  // lowest matching position
  assign first = hits & (~hits + 1'b1);

  always_comb begin
    hit_handle = '0;
    for (int k = 0; k < cidt_pkg::MAX_ENTRIES; k++) begin
      hit_handle = hit_handle | (first[k] ? entries[k].handle : '0);
    end
  end

  always_comb begin
    rsp_next = '0;
    if (op == cidt_pkg::OP_REGISTER) begin
      rsp_next.status = full ? cidt_pkg::ST_FULL : cidt_pkg::ST_REGISTERED;
    end else if (|hits) begin
      rsp_next.status        = cidt_pkg::ST_DELIVERED;
      rsp_next.target_handle = hit_handle;
      rsp_next.frame_data    = payload;
    end else begin
      rsp_next.status = cidt_pkg::ST_NO_MATCH;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op        <= req.op;
      table_sel <= cidt_pkg::pick_table(req.bus, req.extended);
      key       <= req.can_id;
      handle    <= req.device_handle;
      payload   <= req.payload;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
      for (int t = 0; t < cidt_pkg::TABLES; t++) begin
        counts[t] <= '0;
      end
    end else begin
      rsp_valid <= done || (rsp_valid && rsp_stall);
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_LOOK;
          end
        end
        S_LOOK: begin
          if (done) begin
            state <= S_IDLE;
            if (ctl.commit) begin
              counts[table_sel] <= cnt + 1'b1;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      rsp <= rsp_next;
    end
  end

endmodule

@@ tb/tb_can_id_dispatch_table.sv @@
`timescale 1ns / 1ps

import cidt_pkg::*;

class dispatch_scoreboard;
  logic [ID_W-1:0]     ids     [TABLES][MAX_ENTRIES];
  logic [HANDLE_W-1:0] handles [TABLES][MAX_ENTRIES];
  int unsigned         fill    [TABLES];
  rsp_t                awaited [$];
  int unsigned         fails;

  function new();
    foreach (fill[i]) fill[i] = 0;
    fails = 0;
  endfunction

  function int unsigned pending();
    return awaited.size();
  endfunction

  // sorted insert after equal ids; lookup returns lowest matching slot
  function void note_request(req_t w);
    rsp_t        r;
    int unsigned b, t, pos, k;
    r = '0;
    b = (w.bus >= NUM_BUSES) ? NUM_BUSES - 1 : w.bus;
    t = b * 2 + w.extended;
    if (w.op == OP_REGISTER) begin
      if (fill[t] >= MAX_ENTRIES) begin
        r.status = ST_FULL;
      end else begin
        pos = fill[t];
        while (pos > 0 && ids[t][pos-1] > w.can_id) begin
          ids[t][pos]     = ids[t][pos-1];
          handles[t][pos] = handles[t][pos-1];
          pos--;
        end
        ids[t][pos]     = w.can_id;
        handles[t][pos] = w.device_handle;
        fill[t]++;
        r.status = ST_REGISTERED;
      end
    end else begin
      r.status = ST_NO_MATCH;
      for (k = 0; k < fill[t]; k++) begin
        if (ids[t][k] == w.can_id) begin
          r.status        = ST_DELIVERED;
          r.target_handle = handles[t][k];
          r.frame_data    = w.payload;
          break;
        end
      end
    end
    awaited.push_back(r);
  endfunction

  function void flag(string what, logic [63:0] want, logic [63:0] got);
    fails++;
    if (fails <= 10) $display("mismatch %s: expected %h, got %h", what, want, got);
  endfunction

  function void check_response(rsp_t got);
    rsp_t want;
    if (awaited.size() == 0) begin
      fails++;
      if (fails <= 10) $display("unexpected rsp word %h", got);
      return;
    end
    want = awaited.pop_front();
    if (got.status !== want.status) flag("status", 64'(want.status), 64'(got.status));
    if (got.target_handle !== want.target_handle)
      flag("target_handle", 64'(want.target_handle), 64'(got.target_handle));
    if (got.frame_data !== want.frame_data)
      flag("frame_data", want.frame_data, got.frame_data);
  endfunction
endclass

module tb_can_id_dispatch_table;

  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_WORDS = 1025;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  req_t req       = '0;
  logic rsp_stall = 1'b0;
  logic calm      = 1'b0;
  logic req_stall;
  logic rsp_valid;
  rsp_t rsp;

  dispatch_scoreboard sb = new();
  int unsigned        quiet_cycles = 0;

  can_id_dispatch_table dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    rsp_stall <= !calm && ($urandom_range(99) < 21);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && !req_stall) sb.note_request(req);
      if (rsp_valid && !rsp_stall) sb.check_response(rsp);
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  function automatic req_t make_word(op_t op, int bus, logic ext, logic [ID_W-1:0] id,
                                     logic [HANDLE_W-1:0] handle,
                                     logic [PAYLOAD_W-1:0] payload);
    req_t w;
    w.op            = op;
    w.bus           = 2'(bus);
    w.extended      = ext;
    w.can_id        = id;
    w.device_handle = handle;
    w.payload       = payload;
    return w;
  endfunction

  // frames mostly aim at ids already held so that hits are common
  function automatic req_t random_word();
    req_t        w;
    int unsigned b, t, pick;
    w.op            = ($urandom_range(99) < 65) ? OP_FRAME : OP_REGISTER;
    w.bus           = 2'($urandom_range(3));
    w.extended      = 1'($urandom_range(1));
    w.device_handle = 8'($urandom);
    w.payload       = {$urandom, $urandom};
    b = (w.bus >= NUM_BUSES) ? NUM_BUSES - 1 : w.bus;
    t = b * 2 + w.extended;
    pick = $urandom_range(99);
    if (w.op == OP_FRAME && sb.fill[t] != 0 && pick < 60) begin
      w.can_id = sb.ids[t][$urandom_range(sb.fill[t] - 1)];
    end else if (pick < 35 || (w.op == OP_FRAME && pick < 75)) begin
      w.can_id = 29'($urandom_range(15));
    end else if (pick < 85) begin
      case ($urandom_range(3))
        0:       w.can_id = '0;
        1:       w.can_id = '1;
        2:       w.can_id = 29'h7FF;
        default: w.can_id = 29'h800;
      endcase
    end else begin
      w.can_id = 29'($urandom);
    end
    return w;
  endfunction

  task automatic send_word(req_t w);
    while (!calm && $urandom_range(99) < 21) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= w;
    @(posedge clk);
    while (req_stall) @(posedge clk);
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    logic [ID_W-1:0] fill_ids [16];
    fill_ids = '{29'h1FFFFFFF, 29'h0, 29'h7FF, 29'h5, 29'h5, 29'h1FFFF7FF, 29'h800, 29'h3,
                 29'h5, 29'h100, 29'h1FFFFFFE, 29'h2, 29'h7FE, 29'h40, 29'h1, 29'h6};
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    send_word(make_word(OP_FRAME, 0, 1'b0, '0, 8'h00, '1));
    // bus 3 folds onto bus 2; standard table keeps all 29 id bits
    for (int i = 0; i < 16; i++) begin
      send_word(make_word(OP_REGISTER, 3, 1'b0, fill_ids[i],
                          (i == 0) ? 8'hFF : 8'(i * 13), 64'(i)));
    end
    send_word(make_word(OP_REGISTER, 2, 1'b0, 29'h9, 8'h77, '0));
    send_word(make_word(OP_FRAME, 2, 1'b0, 29'h5, 8'h00, 64'h0123456789ABCDEF));
    send_word(make_word(OP_FRAME, 3, 1'b0, 29'h1FFFF7FF, 8'hFF, '0));
    send_word(make_word(OP_FRAME, 2, 1'b0, 29'h1FFFFFFF, 8'h00, '1));
    send_word(make_word(OP_FRAME, 2, 1'b0, 29'h4, 8'h00, '1));
    send_word(make_word(OP_REGISTER, 1, 1'b1, 29'h1FFFFFFF, 8'hAA, '0));
    send_word(make_word(OP_FRAME, 1, 1'b0, 29'h1FFFFFFF, 8'h00, '1));
    send_word(make_word(OP_FRAME, 1, 1'b1, 29'h1FFFFFFF, 8'h00, 64'h5555AAAA5555AAAA));
    drain();

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i == 400) calm <= 1'b1;
      if (i == 600) calm <= 1'b0;
      if (i == 700) drain();
      send_word(random_word());
    end
    drain();

    repeat (8) @(posedge clk);
    if (sb.fails == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/cidt_pkg.sv
design/cidt_cell.sv
design/can_id_dispatch_table.sv
tb/tb_can_id_dispatch_table.sv
